// ===== hw/rtl/ttlb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttlb_pkg
// Shared types and constants for the text terminal line buffer.
// ----------------------------------------------------------------------------
package ttlb_pkg;

    typedef enum logic [1:0] {
        CMD_PRINT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam int CHAR_W   = 7;
    localparam int COLOR_W  = 4;
    localparam int CELL_W   = CHAR_W + COLOR_W;
    localparam int BYTE_W   = 8;
    localparam int ROW_IN_W = 4;
    localparam int COL_IN_W = 6;

    localparam logic [BYTE_W-1:0]  ESC_BYTE     = 8'h1B;
    localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0]  SPACE_BYTE   = 8'h20;
    localparam logic [BYTE_W-1:0]  NUL_BYTE     = 8'h00;
    localparam logic [BYTE_W-1:0]  PALETTE_SIZE = 8'd16;
    localparam logic [COLOR_W-1:0] WHITE        = 4'd1;

    // memory port strobes from the cursor to the store
    typedef struct packed {
        logic cell_we;
        logic fill_we;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic       cell_written;
        logic [1:0] lines_added;
    } t_print_res;

endpackage

// ===== hw/rtl/text_terminal_line_buffer_top.sv =====
// ----------------------------------------------------------------------------
// text_terminal_line_buffer_top
// Scrolling text line store: prints bytes with color escapes, reads cells,
// clears the screen.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+-------------------------------------
//   in      | i_in_valid / o_in_ready    | command, data_byte, first_of_string,
//           |                            | read_row, read_column
//   out     | o_out_valid / i_out_ready  | cell_written, lines_added,
//           |                            | read_char, read_color
//
// One transfer per cycle while out is not stalled; a result is on the out channel
// in the cycle after its input transfer, from the registered read of the cell memory.
// The result register holds while out is stalled; in is ready whenever the
// result register is empty or being taken.
// Reset clears the ring pointers and color state; no memory sweep needed.
// ----------------------------------------------------------------------------
module text_terminal_line_buffer_top #(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_command,
    input  logic [ttlb_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                              i_first_of_string,
    input  logic [ttlb_pkg::ROW_IN_W-1:0]     i_read_row,
    input  logic [ttlb_pkg::COL_IN_W-1:0]     i_read_column,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_cell_written,
    output logic [1:0]                        o_lines_added,
    output logic [ttlb_pkg::CHAR_W-1:0]       o_read_char,
    output logic [ttlb_pkg::COLOR_W-1:0]      o_read_color
);

    localparam int SW  = $clog2(ROWS);
    localparam int FW  = $clog2(COLUMNS + 1);
    localparam int AW  = $clog2(ROWS * COLUMNS);
    localparam int FCW = (FW > ttlb_pkg::COL_IN_W) ? FW : ttlb_pkg::COL_IN_W;

    logic                          accept;
    ttlb_pkg::t_mem_ctl            ctl;
    ttlb_pkg::t_print_res          res;
    logic [AW-1:0]                 cell_waddr, cell_raddr;
    logic [ttlb_pkg::CELL_W-1:0]   cell_wdata, cell_rdata;
    logic [SW-1:0]                 fill_waddr, fill_raddr;
    logic [FW-1:0]                 fill_wdata, fill_rdata, cur_fill, line_fill;
    logic                          row_ok, col_ok, use_cur, hit;

    logic                          r_valid, n_valid;
    ttlb_pkg::t_print_res          r_res;
    logic                          r_row_ok, r_col_ok, r_use_cur;
    logic [ttlb_pkg::COL_IN_W-1:0] r_col;
    logic [FW-1:0]                 r_cur_fill;

    assign o_in_ready = !r_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    ttlb_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (accept),
        .i_command         (ttlb_pkg::t_cmd'(i_command)),
        .i_data_byte       (i_data_byte),
        .i_first_of_string (i_first_of_string),
        .i_read_row        (i_read_row),
        .i_read_column     (i_read_column),
        .o_ctl             (ctl),
        .o_cell_waddr      (cell_waddr),
        .o_cell_wdata      (cell_wdata),
        .o_cell_raddr      (cell_raddr),
        .o_fill_waddr      (fill_waddr),
        .o_fill_wdata      (fill_wdata),
        .o_fill_raddr      (fill_raddr),
        .o_res             (res),
        .o_row_ok          (row_ok),
        .o_col_ok          (col_ok),
        .o_use_cur         (use_cur),
        .o_cur_fill        (cur_fill)
    );

    ttlb_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_cell_waddr (cell_waddr),
        .i_cell_wdata (cell_wdata),
        .i_cell_raddr (cell_raddr),
        .i_fill_waddr (fill_waddr),
        .i_fill_wdata (fill_wdata),
        .i_fill_raddr (fill_raddr),
        .o_cell_rdata (cell_rdata),
        .o_fill_rdata (fill_rdata)
    );

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res      <= res;
            r_row_ok   <= row_ok;
            r_col_ok   <= col_ok;
            r_use_cur  <= use_cur;
            r_col      <= i_read_column;
            r_cur_fill <= cur_fill;
        end
    end

    // newest line fill lives in the cursor; older lines come from memory
    assign line_fill = r_use_cur ? r_cur_fill : fill_rdata;
    assign hit       = r_row_ok && r_col_ok && (FCW'(r_col) < FCW'(line_fill));

    assign o_out_valid    = r_valid;
    assign o_cell_written = r_res.cell_written;
    assign o_lines_added  = r_res.lines_added;
    assign o_read_char    = hit ? cell_rdata[ttlb_pkg::CHAR_W-1:0] : '0;
    assign o_read_color   = hit ? cell_rdata[ttlb_pkg::CELL_W-1:ttlb_pkg::CHAR_W] : '0;

`ifndef SYNTHESIS
    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.rd_en && (ctl.cell_we || ctl.fill_we)))
        else $error("memory read and write in one transfer");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_lines_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cell_written |-> (o_lines_added == 2'd0 || o_lines_added == 2'd1))
        else $error("cell write with more than one new line");

    a_read_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_char != '0 || o_read_color != '0)
        |-> !o_cell_written && o_lines_added == 2'd0)
        else $error("read data on a print result");
`endif

endmodule

// ===== hw/rtl/ttlb_store.sv =====
// ----------------------------------------------------------------------------
// ttlb_store
// Cell memory and line fill memory, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module ttlb_store #(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 16
) (
    input  logic                              i_clk,
    input  ttlb_pkg::t_mem_ctl                i_ctl,
    input  logic [$clog2(ROWS*COLUMNS)-1:0]   i_cell_waddr,
    input  logic [ttlb_pkg::CELL_W-1:0]       i_cell_wdata,
    input  logic [$clog2(ROWS*COLUMNS)-1:0]   i_cell_raddr,
    input  logic [$clog2(ROWS)-1:0]           i_fill_waddr,
    input  logic [$clog2(COLUMNS+1)-1:0]      i_fill_wdata,
    input  logic [$clog2(ROWS)-1:0]           i_fill_raddr,
    output logic [ttlb_pkg::CELL_W-1:0]       o_cell_rdata,
    output logic [$clog2(COLUMNS+1)-1:0]      o_fill_rdata
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int FW    = $clog2(COLUMNS + 1);

    logic [ttlb_pkg::CELL_W-1:0] r_cells [DEPTH];
    logic [FW-1:0]               r_fills [ROWS];
    logic [ttlb_pkg::CELL_W-1:0] r_cell_rdata;
    logic [FW-1:0]               r_fill_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cell_we) begin
            r_cells[i_cell_waddr] <= i_cell_wdata;
        end
        if (i_ctl.rd_en) begin
            r_cell_rdata <= r_cells[i_cell_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_we) begin
            r_fills[i_fill_waddr] <= i_fill_wdata;
        end
        if (i_ctl.rd_en) begin
            r_fill_rdata <= r_fills[i_fill_raddr];
        end
    end

    assign o_cell_rdata = r_cell_rdata;
    assign o_fill_rdata = r_fill_rdata;

endmodule

// ===== hw/rtl/ttlb_cursor.sv =====
// ----------------------------------------------------------------------------
// ttlb_cursor
// Line ring pointers, newest-line fill, color and escape state. Decodes one
// command per transfer into memory accesses and print results.
// ----------------------------------------------------------------------------
module ttlb_cursor #(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  ttlb_pkg::t_cmd                    i_command,
    input  logic [ttlb_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                              i_first_of_string,
    input  logic [ttlb_pkg::ROW_IN_W-1:0]     i_read_row,
    input  logic [ttlb_pkg::COL_IN_W-1:0]     i_read_column,
    output ttlb_pkg::t_mem_ctl                o_ctl,
    output logic [$clog2(ROWS*COLUMNS)-1:0]   o_cell_waddr,
    output logic [ttlb_pkg::CELL_W-1:0]       o_cell_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]   o_cell_raddr,
    output logic [$clog2(ROWS)-1:0]           o_fill_waddr,
    output logic [$clog2(COLUMNS+1)-1:0]      o_fill_wdata,
    output logic [$clog2(ROWS)-1:0]           o_fill_raddr,
    output ttlb_pkg::t_print_res              o_res,
    output logic                              o_row_ok,
    output logic                              o_col_ok,
    output logic                              o_use_cur,
    output logic [$clog2(COLUMNS+1)-1:0]      o_cur_fill
);

    localparam int SW   = $clog2(ROWS);
    localparam int CW   = $clog2(ROWS + 1);
    localparam int FW   = $clog2(COLUMNS + 1);
    localparam int AW   = $clog2(ROWS * COLUMNS);
    localparam int RCW  = (CW > ttlb_pkg::ROW_IN_W) ? CW : ttlb_pkg::ROW_IN_W;
    localparam int SUMW = ((SW > ttlb_pkg::ROW_IN_W) ? SW : ttlb_pkg::ROW_IN_W) + 1;
    localparam int CCW  = 7;

    typedef struct packed {
        logic [SW-1:0] oldest;
        logic [SW-1:0] newest;
        logic [CW-1:0] count;
        logic [FW-1:0] fill;
    } t_cur;

    t_cur                         r_cur, n_cur;
    logic [ttlb_pkg::COLOR_W-1:0] r_color, n_color;
    logic                         r_esc, n_esc;
    logic                         r_ended, n_ended;

    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] s);
        f_inc = (s == SW'(ROWS - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic t_cur f_start_line(input t_cur c);
        t_cur r;
        r = c;
        if (c.count == '0) begin
            r.newest = c.oldest;
            r.count  = CW'(1);
        end else begin
            r.newest = f_inc(c.newest);
            if (c.count == CW'(ROWS)) begin
                r.oldest = f_inc(c.oldest);
            end else begin
                r.count = c.count + 1'b1;
            end
        end
        r.fill = '0;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_color <= ttlb_pkg::WHITE;
            r_esc   <= 1'b0;
            r_ended <= 1'b0;
        end else if (i_step) begin
            r_cur   <= n_cur;
            r_color <= n_color;
            r_esc   <= n_esc;
            r_ended <= n_ended;
        end
    end

    // print and clear, and the read strobe
    always_comb begin
        logic [ttlb_pkg::BYTE_W-1:0] b;
        b            = i_data_byte;
        n_cur        = r_cur;
        n_color      = r_color;
        n_esc        = r_esc;
        n_ended      = r_ended;
        o_res        = '0;
        o_ctl        = '0;
        o_cell_waddr = '0;
        o_cell_wdata = '0;
        o_fill_waddr = '0;
        o_fill_wdata = '0;
        case (i_command)
            ttlb_pkg::CMD_PRINT: begin
                if (i_first_of_string) begin
                    n_color = ttlb_pkg::WHITE;
                    n_esc   = 1'b0;
                    n_ended = 1'b0;
                end
                if (!n_ended) begin
                    if (n_cur.count == '0) begin
                        n_cur = f_start_line(n_cur);
                        o_res.lines_added = o_res.lines_added + 1'b1;
                    end
                    if (n_esc) begin
                        n_esc = 1'b0;
                        if (b == ttlb_pkg::NUL_BYTE) begin
                            n_ended = 1'b1;
                        end else if (b < ttlb_pkg::PALETTE_SIZE) begin
                            n_color = b[ttlb_pkg::COLOR_W-1:0];
                        end else begin
                            n_color = ttlb_pkg::WHITE;
                        end
                    end else if (b == ttlb_pkg::NUL_BYTE) begin
                        n_ended = 1'b1;
                    end else begin
                        // a full line is already recorded through write-through
                        if (n_cur.fill == FW'(COLUMNS)) begin
                            n_cur = f_start_line(n_cur);
                            o_res.lines_added = o_res.lines_added + 1'b1;
                        end
                        if (b == ttlb_pkg::ESC_BYTE) begin
                            n_esc = 1'b1;
                        end else if (b == ttlb_pkg::NEWLINE_BYTE) begin
                            // record the closing line's fill
                            o_ctl.fill_we = i_step;
                            o_fill_waddr  = n_cur.newest;
                            o_fill_wdata  = n_cur.fill;
                            n_cur = f_start_line(n_cur);
                            o_res.lines_added = o_res.lines_added + 1'b1;
                        end else if (!b[7] && b >= ttlb_pkg::SPACE_BYTE) begin
                            o_ctl.cell_we = i_step;
                            o_cell_waddr  = AW'(n_cur.newest) * AW'(COLUMNS) + AW'(n_cur.fill);
                            o_cell_wdata  = {n_color, b[ttlb_pkg::CHAR_W-1:0]};
                            n_cur.fill    = n_cur.fill + 1'b1;
                            o_ctl.fill_we = i_step;
                            o_fill_waddr  = n_cur.newest;
                            o_fill_wdata  = n_cur.fill;
                            o_res.cell_written = 1'b1;
                        end
                    end
                end
            end
            ttlb_pkg::CMD_CLEAR: begin
                n_cur.oldest = '0;
                n_cur.count  = '0;
            end
            default: ;
        endcase
        o_ctl.rd_en = i_step && (i_command == ttlb_pkg::CMD_READ);
    end

    // read address
    always_comb begin
        logic [SUMW-1:0] sum;
        logic [SW-1:0]   slot;
        logic            col_ok;
        sum      = SUMW'(r_cur.oldest) + SUMW'(i_read_row);
        if (sum >= SUMW'(ROWS)) begin
            sum = sum - SUMW'(ROWS);
        end
        o_row_ok = (i_command == ttlb_pkg::CMD_READ) &&
                   (RCW'(i_read_row) < RCW'(r_cur.count));
        slot     = o_row_ok ? SW'(sum) : '0;
        col_ok   = {1'b0, i_read_column} < CCW'(COLUMNS);
        o_col_ok = col_ok;
        o_cell_raddr = AW'(slot) * AW'(COLUMNS) +
                       (col_ok ? AW'(i_read_column) : '0);
        o_fill_raddr = slot;
        o_use_cur    = (slot == r_cur.newest);
        o_cur_fill   = r_cur.fill;
    end

endmodule

// ===== sim/text_terminal_line_buffer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_terminal_line_buffer_top_tb
// Drives print, read, clear and no-op commands into the line buffer with
// random idle and stall bursts. A scoreboard keeps its own copy of the
// screen (cells, line fills, ring pointer, color and escape state) and
// checks every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module text_terminal_line_buffer_top_tb;

    localparam int COLUMNS = 64;
    localparam int ROWS    = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_TAIL   = 120;

    typedef struct {
        ttlb_pkg::t_cmd                cmd;
        logic [ttlb_pkg::BYTE_W-1:0]   data;
        logic                          first;
        logic [ttlb_pkg::ROW_IN_W-1:0] row;
        logic [ttlb_pkg::COL_IN_W-1:0] col;
    } t_request;

    typedef struct packed {
        logic                         written;
        logic [1:0]                   added;
        logic [ttlb_pkg::CHAR_W-1:0]  chr;
        logic [ttlb_pkg::COLOR_W-1:0] color;
    } t_response;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [1:0]                    i_command = 2'd0;
    logic [ttlb_pkg::BYTE_W-1:0]   i_data_byte = '0;
    logic                          i_first_of_string = 1'b0;
    logic [ttlb_pkg::ROW_IN_W-1:0] i_read_row = '0;
    logic [ttlb_pkg::COL_IN_W-1:0] i_read_column = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_cell_written;
    logic [1:0]                    o_lines_added;
    logic [ttlb_pkg::CHAR_W-1:0]   o_read_char;
    logic [ttlb_pkg::COLOR_W-1:0]  o_read_color;

    text_terminal_line_buffer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_data_byte      (i_data_byte),
        .i_first_of_string(i_first_of_string),
        .i_read_row       (i_read_row),
        .i_read_column    (i_read_column),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cell_written   (o_cell_written),
        .o_lines_added    (o_lines_added),
        .o_read_char      (o_read_char),
        .o_read_color     (o_read_color)
    );

    always #1 i_clk = ~i_clk;

    // screen copy
    logic [ttlb_pkg::CELL_W-1:0]  scr_cells [ROWS*COLUMNS];
    int unsigned                  scr_fill [ROWS];
    int unsigned                  scr_oldest = 0;
    int unsigned                  scr_lines = 0;
    logic [ttlb_pkg::COLOR_W-1:0] scr_color = ttlb_pkg::WHITE;
    bit                           scr_esc = 1'b0;
    bit                           scr_ended = 1'b0;

    t_request  pending_requests [$];
    t_response expected_responses [$];
    t_request  held;
    t_response want;
    int        queued_items = 0;
    int        mismatches = 0;
    int        in_gap = 0;
    int        stall_left = 0;

    function automatic int unsigned row_slot(int unsigned r);
        int unsigned s;
        s = scr_oldest + r;
        if (s >= ROWS) s -= ROWS;
        return s;
    endfunction

    function automatic void open_line();
        int unsigned s;
        if (scr_lines < ROWS) begin
            s = row_slot(scr_lines);
            scr_lines++;
        end else begin
            s = scr_oldest;
            scr_oldest = row_slot(1);
        end
        scr_fill[s] = 0;
    endfunction

    function automatic t_response terminal_response(t_request q);
        t_response   p;
        int unsigned tail_slot;
        int unsigned s;
        p = '0;
        case (q.cmd)
            ttlb_pkg::CMD_PRINT: begin
                if (q.first) begin
                    scr_color = ttlb_pkg::WHITE;
                    scr_esc   = 1'b0;
                    scr_ended = 1'b0;
                end
                if (!scr_ended) begin
                    if (scr_lines == 0) begin
                        open_line();
                        p.added = p.added + 2'd1;
                    end
                    if (scr_esc) begin
                        scr_esc = 1'b0;
                        if (q.data == ttlb_pkg::NUL_BYTE) scr_ended = 1'b1;
                        else scr_color = (q.data < ttlb_pkg::PALETTE_SIZE)
                                         ? q.data[ttlb_pkg::COLOR_W-1:0] : ttlb_pkg::WHITE;
                    end else if (q.data == ttlb_pkg::NUL_BYTE) begin
                        scr_ended = 1'b1;
                    end else begin
                        tail_slot = row_slot(scr_lines - 1);
                        if (scr_fill[tail_slot] >= COLUMNS) begin
                            open_line();
                            p.added = p.added + 2'd1;
                            tail_slot = row_slot(scr_lines - 1);
                        end
                        if (q.data == ttlb_pkg::ESC_BYTE) begin
                            scr_esc = 1'b1;
                        end else if (q.data == ttlb_pkg::NEWLINE_BYTE) begin
                            open_line();
                            p.added = p.added + 2'd1;
                        end else if (q.data >= ttlb_pkg::SPACE_BYTE && q.data < 8'h80) begin
                            scr_cells[tail_slot*COLUMNS + scr_fill[tail_slot]] =
                                {scr_color, q.data[ttlb_pkg::CHAR_W-1:0]};
                            scr_fill[tail_slot]++;
                            p.written = 1'b1;
                        end
                    end
                end
            end
            ttlb_pkg::CMD_READ: begin
                if (q.row < scr_lines) begin
                    s = row_slot(q.row);
                    if (q.col < scr_fill[s]) begin
                        p.chr   = scr_cells[s*COLUMNS + q.col][ttlb_pkg::CHAR_W-1:0];
                        p.color = scr_cells[s*COLUMNS + q.col]
                                  [ttlb_pkg::CELL_W-1:ttlb_pkg::CHAR_W];
                    end
                end
            end
            ttlb_pkg::CMD_CLEAR: begin
                scr_lines  = 0;
                scr_oldest = 0;
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic t_request make_request(ttlb_pkg::t_cmd cmd, logic [7:0] data,
                                              logic first, logic [3:0] row,
                                              logic [5:0] col);
        t_request q;
        q.cmd   = cmd;
        q.data  = data;
        q.first = first;
        q.row   = row;
        q.col   = col;
        return q;
    endfunction

    task automatic push_print(logic [7:0] data, logic first);
        pending_requests.push_back(make_request(ttlb_pkg::CMD_PRINT, data, first,
                                   4'($urandom), 6'($urandom)));
        queued_items++;
    endtask

    task automatic push_read(logic [3:0] row, logic [5:0] col);
        pending_requests.push_back(make_request(ttlb_pkg::CMD_READ, 8'($urandom),
                                   1'($urandom), row, col));
        queued_items++;
    endtask

    task automatic push_other(ttlb_pkg::t_cmd cmd);
        pending_requests.push_back(make_request(cmd, 8'($urandom), 1'($urandom),
                                   4'($urandom), 6'($urandom)));
        queued_items++;
    endtask

    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return ttlb_pkg::NEWLINE_BYTE;
        if (pick < 12) return ttlb_pkg::ESC_BYTE;
        if (pick < 15) return $urandom_range(0, 1) ? 8'($urandom_range(1, 31))
                                                  : 8'($urandom_range(128, 255));
        return 8'($urandom_range(32, 127));
    endfunction

    function automatic logic [7:0] color_index();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return ttlb_pkg::NUL_BYTE;
        if (pick == 1) return 8'($urandom_range(16, 255));
        return 8'($urandom_range(1, 15));
    endfunction

    task automatic push_string();
        int         len;
        logic [7:0] b;
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 30);
        for (int k = 0; k < len; k++) begin
            b = text_byte();
            push_print(b, k == 0);
            if (b == ttlb_pkg::ESC_BYTE) push_print(color_index(), 1'b0);
        end
        if ($urandom_range(0, 3) == 0) begin
            push_print(ttlb_pkg::NUL_BYTE, 1'b0);
            // bytes after the terminator are dropped by the block
            repeat ($urandom_range(0, 3))
                pending_requests.push_back(make_request(ttlb_pkg::CMD_PRINT, 8'($urandom),
                                           1'b0, 4'($urandom), 6'($urandom)));
        end
    endtask

    function automatic bit idling_allowed();
        int left;
        left = pending_requests.size();
        return left >= QUIET_TAIL && (left / 90) % 3 != 0;
    endfunction

    task automatic report_mismatch(string field, int got, int exp_v);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, exp_v);
        mismatches++;
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_responses.push_back(terminal_response(held));
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    held = pending_requests.pop_front();
                    i_command         <= held.cmd;
                    i_data_byte       <= held.data;
                    i_first_of_string <= held.first;
                    i_read_row        <= held.row;
                    i_read_column     <= held.col;
                    i_in_valid        <= 1'b1;
                    if (idling_allowed() && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 5);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 6) == 0)
                stall_left = $urandom_range(1, 5);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_responses.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = expected_responses.pop_front();
                if (o_cell_written !== want.written)
                    report_mismatch("cell_written", o_cell_written, want.written);
                if (o_lines_added !== want.added)
                    report_mismatch("lines_added", o_lines_added, want.added);
                if (o_read_char !== want.chr)
                    report_mismatch("read_char", o_read_char, want.chr);
                if (o_read_color !== want.color)
                    report_mismatch("read_color", o_read_color, want.color);
            end
        end
    end

    initial begin
        int pick;
        // directed
        push_read(4'd0, 6'd0);
        push_print("A", 1'b1);
        push_print(ttlb_pkg::ESC_BYTE, 1'b0);
        push_print(8'h05, 1'b0);
        push_print("~", 1'b0);
        push_print(ttlb_pkg::ESC_BYTE, 1'b0);
        push_print(8'hFF, 1'b0);
        push_print(8'h7F, 1'b0);
        push_print(8'h80, 1'b0);
        push_print(8'h01, 1'b0);
        push_print(ttlb_pkg::NEWLINE_BYTE, 1'b0);
        push_print(ttlb_pkg::ESC_BYTE, 1'b0);
        push_print(ttlb_pkg::NUL_BYTE, 1'b0);
        push_print("B", 1'b0);
        push_print(ttlb_pkg::NUL_BYTE, 1'b1);
        push_print(ttlb_pkg::ESC_BYTE, 1'b1);
        push_print("E", 1'b1);
        push_read(4'd0, 6'd1);
        push_read(4'd1, 6'd0);
        push_read(4'd15, 6'd63);
        pending_requests.push_back(make_request(ttlb_pkg::CMD_NOP, 8'hFF, 1'b1,
                                                4'hF, 6'h3F));
        push_other(ttlb_pkg::CMD_CLEAR);
        push_read(4'd0, 6'd0);
        push_print(ttlb_pkg::SPACE_BYTE, 1'b0);
        push_read(4'd0, 6'd0);

        queued_items = 0;
        while (queued_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                push_string();
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 4))
                    push_read(4'($urandom_range(0, 15)),
                              $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, 12)));
            end else if (pick < 90) begin
                push_other(ttlb_pkg::CMD_CLEAR);
            end else if (pick < 94) begin
                push_other(ttlb_pkg::CMD_NOP);
            end else begin
                push_print(8'($urandom), 1'($urandom));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || i_in_valid || expected_responses.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== text_terminal_line_buffer_top.f =====
hw/rtl/ttlb_pkg.sv
hw/rtl/ttlb_store.sv
hw/rtl/ttlb_cursor.sv
hw/rtl/text_terminal_line_buffer_top.sv
sim/text_terminal_line_buffer_top_tb.sv
